### hw/rtl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and fixed constants for the rank sort engine.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int DATA_W    = 32;
    // Element store is split in two banks so one set can load while another sorts
    localparam int NUM_BANKS = 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEY  = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_EMIT = 4'b1000
    } back_state_t;

endpackage

### hw/rtl/rse_ram.sv
// ----------------------------------------------------------------------------
// rse_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/rse_front.sv
// ----------------------------------------------------------------------------
// rse_front
// Input side: writes each beat into the current bank and closes the set
// on last or when the bank is full, handing a job to the queue.
// ----------------------------------------------------------------------------
module rse_front #(
    parameter int MAX_ELEMENTS = 64,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7,
    parameter int BANK_W       = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  rse_pkg::item_t                  item,
    input  logic                            q_full,
    output logic                            elem_we,
    output logic [BANK_W+IDX_W-1:0]         elem_waddr,
    output logic [rse_pkg::DATA_W-1:0]      elem_wdata,
    output logic                            push,
    output logic [BANK_W-1:0]               push_bank,
    output logic [CNT_W-1:0]                push_count
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BANK_W-1:0] bank_reg, bank_next;
    logic              accept;
    logic [CNT_W-1:0]  count_inc;
    logic              set_end;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign count_inc  = count_reg + CNT_W'(1);
    assign set_end    = item.last || (count_inc == CNT_W'(MAX_ELEMENTS));

    assign elem_we    = accept;
    assign elem_waddr = {bank_reg, count_reg[IDX_W-1:0]};
    assign elem_wdata = item.value;
    assign push       = accept && set_end;
    assign push_bank  = bank_reg;
    assign push_count = count_inc;

    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (set_end)
            begin
                count_next = '0;
                bank_next  = bank_reg + BANK_W'(1);
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(MAX_ELEMENTS))
        else $error("set fill count reached bank size");
`endif

endmodule

### hw/rtl/rse_job_queue.sv
// ----------------------------------------------------------------------------
// rse_job_queue
// Short queue of closed sets (bank and element count) between front and back.
// The head stays put until the back end has issued the read of its last sorted value.
// ----------------------------------------------------------------------------
module rse_job_queue #(
    parameter int CNT_W  = 7,
    parameter int BANK_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [BANK_W-1:0] push_bank,
    input  logic [CNT_W-1:0]  push_count,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output logic [BANK_W-1:0] head_bank,
    output logic [CNT_W-1:0]  head_count
);

    localparam int PTR_W = $clog2(rse_pkg::NUM_BANKS);
    localparam int OCC_W = $clog2(rse_pkg::NUM_BANKS + 1);

    logic [BANK_W-1:0] bank_q  [rse_pkg::NUM_BANKS];
    logic [CNT_W-1:0]  count_q [rse_pkg::NUM_BANKS];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    assign full       = (occ_reg == OCC_W'(rse_pkg::NUM_BANKS));
    assign head_valid = (occ_reg != '0);
    assign head_bank  = bank_q[rd_ptr_reg];
    assign head_count = count_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bank_q[wr_ptr_reg]  <= push_bank;
            count_q[wr_ptr_reg] <= push_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");
`endif

endmodule

### hw/rtl/rse_back.sv
// ----------------------------------------------------------------------------
// rse_back
// Sort sequencer: ranks each element of the head job against the whole set,
// one compare a cycle, scatters it into the sorted RAM at its rank, then
// streams the sorted RAM out through a two-beat output buffer.
// ----------------------------------------------------------------------------
module rse_back #(
    parameter int IDX_W  = 6,
    parameter int CNT_W  = 7,
    parameter int BANK_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  logic [BANK_W-1:0]          job_bank,
    input  logic [CNT_W-1:0]           job_count,
    output logic                       job_pop,
    output logic                       elem_re,
    output logic [BANK_W+IDX_W-1:0]    elem_raddr,
    input  logic [rse_pkg::DATA_W-1:0] elem_rdata,
    output logic                       sort_we,
    output logic [IDX_W-1:0]           sort_waddr,
    output logic [rse_pkg::DATA_W-1:0] sort_wdata,
    output logic                       sort_re,
    output logic [IDX_W-1:0]           sort_raddr,
    input  logic [rse_pkg::DATA_W-1:0] sort_rdata,
    output logic                       result_valid,
    input  logic                       result_stall,
    output rse_pkg::result_t           result
);

    localparam int OUT_DEPTH = 2;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCC_W     = $clog2(OUT_DEPTH + 2);

    rse_pkg::back_state_t state_reg, state_next;

    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic [IDX_W-1:0]           e_reg, e_next;
    logic [IDX_W-1:0]           rank_reg, rank_next;
    logic [rse_pkg::DATA_W-1:0] val_i_reg;
    logic                       pend_reg, pend_next;
    logic                       pend_last_reg, pend_last_next;

    rse_pkg::result_t           fifo_q [OUT_DEPTH];
    logic [OPTR_W-1:0]          fifo_wptr_reg, fifo_rptr_reg;
    logic [OCC_W-1:0]           fifo_cnt_reg, fifo_cnt_next;

    logic [CNT_W-1:0]           n_last;
    logic                       i_last, j_last, e_last;
    logic                       less;
    logic [IDX_W-1:0]           rank_upd;
    logic                       result_pop;
    logic [OCC_W-1:0]           occ;
    logic                       issue_ok;

    assign n_last   = job_count - CNT_W'(1);
    assign i_last   = (CNT_W'(i_reg) == n_last);
    assign j_last   = (CNT_W'(j_reg) == n_last);
    assign e_last   = (CNT_W'(e_reg) == n_last);

    // equal keys: the earlier arrival ranks lower, keeping the sort stable
    assign less     = ($signed(elem_rdata) < $signed(val_i_reg))
                   || ((elem_rdata == val_i_reg) && (j_reg < i_reg));
    assign rank_upd = rank_reg + IDX_W'(less);

    assign result_valid = (fifo_cnt_reg != '0);
    assign result       = fifo_q[fifo_rptr_reg];
    assign result_pop   = result_valid && !result_stall;

    // buffered beats plus the read in flight, less the beat leaving now
    assign occ      = fifo_cnt_reg + OCC_W'(pend_reg) - OCC_W'(result_pop);
    assign issue_ok = (occ < OCC_W'(OUT_DEPTH));

    assign sort_waddr = rank_upd;
    assign sort_wdata = val_i_reg;
    assign sort_raddr = e_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        e_next         = e_reg;
        rank_next      = rank_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        elem_re        = 1'b0;
        elem_raddr     = {job_bank, i_reg};
        sort_we        = 1'b0;
        sort_re        = 1'b0;
        job_pop        = 1'b0;
        case (state_reg)
            rse_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    elem_re    = 1'b1;
                    elem_raddr = {job_bank, IDX_W'(0)};
                    i_next     = '0;
                    state_next = rse_pkg::ST_KEY;
                end
            end
            rse_pkg::ST_KEY:
            begin
                elem_re    = 1'b1;
                elem_raddr = {job_bank, IDX_W'(0)};
                j_next     = '0;
                rank_next  = '0;
                state_next = rse_pkg::ST_CMP;
            end
            rse_pkg::ST_CMP:
            begin
                if (j_last)
                begin
                    sort_we = 1'b1;
                    if (i_last)
                    begin
                        e_next     = '0;
                        state_next = rse_pkg::ST_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        elem_re    = 1'b1;
                        elem_raddr = {job_bank, i_reg + IDX_W'(1)};
                        state_next = rse_pkg::ST_KEY;
                    end
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    rank_next  = rank_upd;
                    elem_re    = 1'b1;
                    elem_raddr = {job_bank, j_reg + IDX_W'(1)};
                end
            end
            rse_pkg::ST_EMIT:
            begin
                if (issue_ok)
                begin
                    sort_re        = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = e_last;
                    if (e_last)
                    begin
                        job_pop    = 1'b1;
                        state_next = rse_pkg::ST_IDLE;
                    end
                    else
                    begin
                        e_next = e_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = rse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (pend_reg && !result_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + OCC_W'(1);
        end
        else if (!pend_reg && result_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - OCC_W'(1);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (state_reg == rse_pkg::ST_KEY)
        begin
            val_i_reg <= elem_rdata;
        end
        if (pend_reg)
        begin
            fifo_q[fifo_wptr_reg].sorted_value <= $signed(sort_rdata);
            fifo_q[fifo_wptr_reg].last_out     <= pend_last_reg;
        end
        i_reg          <= i_next;
        j_reg          <= j_next;
        e_reg          <= e_next;
        rank_reg       <= rank_next;
        pend_last_reg  <= pend_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rse_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            fifo_wptr_reg <= '0;
            fifo_rptr_reg <= '0;
            fifo_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            fifo_cnt_reg <= fifo_cnt_next;
            if (pend_reg)
            begin
                fifo_wptr_reg <= fifo_wptr_reg + OPTR_W'(1);
            end
            if (result_pop)
            begin
                fifo_rptr_reg <= fifo_rptr_reg + OPTR_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_rank_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        sort_we |-> (CNT_W'(rank_upd) <= n_last))
        else $error("rank outside current set");

    a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (fifo_cnt_reg == OCC_W'(OUT_DEPTH))) |-> result_pop)
        else $error("output buffer overflow");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rse_pkg::ST_KEY) || (state_reg == rse_pkg::ST_CMP)
            || (state_reg == rse_pkg::ST_EMIT)) |-> job_valid)
        else $error("job left the queue while being sorted");

    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (pend_reg && pend_last_reg))
        else $error("job released before its last beat was read");
`endif

endmodule

### hw/rtl/rank_sort_engine.sv
// ----------------------------------------------------------------------------
// rank_sort_engine
// Stable rank (enumeration) sort of sets of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one value per beat, a set
//   closes on item.last or when MAX_ELEMENTS values have been taken.
//   result channel (result_valid / result_stall / result): the set comes
//   back in ascending order, equal values in arrival order, last_out set on
//   the final beat of each set.
//   Sorting a set compares on the element RAM read port, one compare per
//   cycle; the sorted set is then emitted at one beat per cycle while
//   result_stall is low, each beat read from the sorted RAM and registered
//   into the output buffer before it is offered.
//   The element RAM holds two banks, so a second set can load while one is
//   sorted; item_stall rises while both banks hold closed sets.
//   result_stall holds the two-beat output buffer; emission pauses, nothing
//   is lost. Reset empties the job queue and output buffer and drops any
//   partly loaded set; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module rank_sort_engine #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  rse_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output rse_pkg::result_t result
);

    localparam int IDX_W      = $clog2(MAX_ELEMENTS);
    localparam int CNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int BANK_W     = $clog2(rse_pkg::NUM_BANKS);
    localparam int ELEM_DEPTH = rse_pkg::NUM_BANKS * (2 ** IDX_W);

    logic                       q_full;
    logic                       push;
    logic [BANK_W-1:0]          push_bank;
    logic [CNT_W-1:0]           push_count;
    logic                       job_valid;
    logic [BANK_W-1:0]          job_bank;
    logic [CNT_W-1:0]           job_count;
    logic                       job_pop;

    logic                       elem_we;
    logic [BANK_W+IDX_W-1:0]    elem_waddr;
    logic [rse_pkg::DATA_W-1:0] elem_wdata;
    logic                       elem_re;
    logic [BANK_W+IDX_W-1:0]    elem_raddr;
    logic [rse_pkg::DATA_W-1:0] elem_rdata;

    logic                       sort_we;
    logic [IDX_W-1:0]           sort_waddr;
    logic [rse_pkg::DATA_W-1:0] sort_wdata;
    logic                       sort_re;
    logic [IDX_W-1:0]           sort_raddr;
    logic [rse_pkg::DATA_W-1:0] sort_rdata;

    rse_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W),
        .BANK_W       (BANK_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .elem_we    (elem_we),
        .elem_waddr (elem_waddr),
        .elem_wdata (elem_wdata),
        .push       (push),
        .push_bank  (push_bank),
        .push_count (push_count)
    );

    rse_job_queue #(
        .CNT_W  (CNT_W),
        .BANK_W (BANK_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_bank  (push_bank),
        .push_count (push_count),
        .pop        (job_pop),
        .full       (q_full),
        .head_valid (job_valid),
        .head_bank  (job_bank),
        .head_count (job_count)
    );

    rse_ram #(
        .WIDTH (rse_pkg::DATA_W),
        .DEPTH (ELEM_DEPTH)
    ) u_elem_ram (
        .clk     (clk),
        .wr_en   (elem_we),
        .wr_addr (elem_waddr),
        .wr_data (elem_wdata),
        .rd_en   (elem_re),
        .rd_addr (elem_raddr),
        .rd_data (elem_rdata)
    );

    rse_ram #(
        .WIDTH (rse_pkg::DATA_W),
        .DEPTH (2 ** IDX_W)
    ) u_sort_ram (
        .clk     (clk),
        .wr_en   (sort_we),
        .wr_addr (sort_waddr),
        .wr_data (sort_wdata),
        .rd_en   (sort_re),
        .rd_addr (sort_raddr),
        .rd_data (sort_rdata)
    );

    rse_back #(
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W),
        .BANK_W (BANK_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_bank     (job_bank),
        .job_count    (job_count),
        .job_pop      (job_pop),
        .elem_re      (elem_re),
        .elem_raddr   (elem_raddr),
        .elem_rdata   (elem_rdata),
        .sort_we      (sort_we),
        .sort_waddr   (sort_waddr),
        .sort_wdata   (sort_wdata),
        .sort_re      (sort_re),
        .sort_raddr   (sort_raddr),
        .sort_rdata   (sort_rdata),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### tb/sv/tb_rank_sort_engine.sv
// ----------------------------------------------------------------------------
// tb_rank_sort_engine
// Self-checking bench for the stable rank sort engine. A directed table
// covers the edge values, ties and the full-store close; random sets follow.
// Multi-value sets are sorted by a local model and every result beat is
// compared in order. Sender and receiver throttle at varying rates.
// ----------------------------------------------------------------------------
module tb_rank_sort_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_CAP      = 64;
    localparam int RANDOM_BEATS = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_ROWS     = 14;

    localparam logic signed [rse_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(rse_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [rse_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(rse_pkg::DATA_W-1){1'b1}}};

    typedef enum int { SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES, SPREAD_MIXED } spread_t;

    // One table row expands to `beats` values first, first+stride, ...;
    // `close` sets last on the final beat only.
    typedef struct {
        logic signed [rse_pkg::DATA_W-1:0] first;
        logic signed [rse_pkg::DATA_W-1:0] stride;
        int                                beats;
        logic                              close;
        logic                              typed;
        logic signed [rse_pkg::DATA_W-1:0] typed_out;
    } stim_row_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    rse_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    rse_pkg::result_t result;

    logic signed [rse_pkg::DATA_W-1:0] open_set [$];
    rse_pkg::result_t                  sorted_due [$];
    stim_row_t                         stim_table [NUM_ROWS];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fault_count   = 0;
    int beats_sent    = 0;
    int sets_closed   = 0;
    int results_seen  = 0;
    int cycle_count   = 0;

    rank_sort_engine #(.MAX_ELEMENTS(SET_CAP)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    // Stable rank: smaller values plus equal values that arrived earlier.
    task automatic rank_and_release();
        logic signed [rse_pkg::DATA_W-1:0] slot [SET_CAP];
        rse_pkg::result_t                  beat;
        int                                n;
        int                                r;
        n = open_set.size();
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int j = 0; j < n; j++)
                if (open_set[j] < open_set[i] || (open_set[j] == open_set[i] && j < i))
                    r++;
            slot[r] = open_set[i];
        end
        for (int p = 0; p < n; p++)
        begin
            beat.sorted_value = slot[p];
            beat.last_out     = (p == n - 1);
            sorted_due.push_back(beat);
        end
        open_set.delete();
        sets_closed++;
    endtask

    task automatic absorb_beat(input rse_pkg::item_t beat);
        open_set.push_back(beat.value);
        if (beat.last || open_set.size() == SET_CAP)
            rank_and_release();
    endtask

    // Returns at the edge that accepts the beat; valid stays high for the caller.
    task automatic send_beat(input rse_pkg::item_t beat);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            item       <= rse_pkg::item_t'({$urandom, 1'($urandom)});
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
            @(posedge clk);
        while (item_stall);
        beats_sent++;
    endtask

    function automatic logic signed [rse_pkg::DATA_W-1:0] edge_value();
        case ($urandom_range(0, 6))
            0: return VAL_MIN;
            1: return VAL_MIN + 1;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return VAL_MAX - 1;
            default: return VAL_MAX;
        endcase
    endfunction

    task automatic random_set(inout int budget);
        rse_pkg::item_t beat;
        spread_t        spread;
        int             size;
        logic           close_at_full;
        if ($urandom_range(0, 24) == 0)
            size = SET_CAP;
        else if ($urandom_range(0, 4) == 0)
            size = $urandom_range(11, 24);
        else
            size = $urandom_range(1, 10);
        close_at_full = 1'($urandom);
        spread = spread_t'($urandom_range(0, 3));
        for (int k = 0; k < size; k++)
        begin
            case (spread)
                SPREAD_WIDE:   beat.value = $urandom;
                SPREAD_NARROW: beat.value = $signed($urandom_range(0, 6)) - 3;
                SPREAD_EDGES:  beat.value = edge_value();
                default:       beat.value = $urandom_range(0, 1) ? $urandom : edge_value();
            endcase
            // a full set closes by itself; last on its 64th beat only sometimes
            beat.last = (k == size - 1) && (size < SET_CAP || close_at_full);
            send_beat(beat);
            absorb_beat(beat);
            budget--;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rse_pkg::result_t due;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (sorted_due.size() == 0)
                    report_fault($sformatf("unexpected result beat: value %0d last %0b",
                                           result.sorted_value, result.last_out));
                else
                begin
                    due = sorted_due.pop_front();
                    if (result.sorted_value !== due.sorted_value ||
                        result.last_out !== due.last_out)
                        report_fault($sformatf(
                            "result mismatch: expected value %0d last %0b, got value %0d last %0b",
                            due.sorted_value, due.last_out,
                            result.sorted_value, result.last_out));
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        rse_pkg::item_t beat;
        int             budget;
        stim_table = '{
            '{VAL_MIN,      0,            1,       1'b1, 1'b1, VAL_MIN},
            '{VAL_MAX,      0,            1,       1'b1, 1'b1, VAL_MAX},
            '{0,            0,            1,       1'b1, 1'b1, 0},
            '{-1,           0,            1,       1'b1, 1'b1, -1},
            '{VAL_MAX,      1,            2,       1'b1, 1'b0, 0},   // max then wraps to min
            '{5,            0,            4,       1'b1, 1'b0, 0},   // ties
            '{-2,           1,            5,       1'b1, 1'b0, 0},   // across zero, ascending
            '{100,          -50,          6,       1'b1, 1'b0, 0},   // across zero, descending
            '{1000,         -3,           SET_CAP, 1'b0, 1'b0, 0},   // store fills, no last
            '{42,           0,            1,       1'b1, 1'b1, 42},  // fresh set after full close
            '{VAL_MIN,      32'sh0400_0000, SET_CAP, 1'b1, 1'b0, 0}, // full and last together
            '{32'sh5555_5555, 32'sh5555_5555, 3,   1'b1, 1'b0, 0},
            '{7,            0,            2,       1'b1, 1'b0, 0},
            '{-7,           0,            1,       1'b1, 1'b1, -7}
        };

        send_idle_pct = 9;
        recv_idle_pct = 48;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[r])
        begin
            for (int k = 0; k < stim_table[r].beats; k++)
            begin
                beat.value = stim_table[r].first + k * stim_table[r].stride;
                beat.last  = stim_table[r].close && (k == stim_table[r].beats - 1);
                send_beat(beat);
                if (stim_table[r].typed)
                begin
                    // single-value set: comes straight back flagged last
                    sorted_due.push_back('{sorted_value: stim_table[r].typed_out, last_out: 1'b1});
                    sets_closed++;
                end
                else
                    absorb_beat(beat);
            end
        end

        budget = RANDOM_BEATS;
        while (budget > 0)
        begin
            if (budget > 2 * RANDOM_BEATS / 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 48;
            end
            else if (budget > RANDOM_BEATS / 3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_set(budget);
        end
        item_valid <= 1'b0;

        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d value beats in %0d sets, checked %0d sorted beats",
                 beats_sent, sets_closed, results_seen);
        $display("Covered edge values, ties, full-store closes and three throttle mixes");
        if (fault_count == 0 && sorted_due.size() == 0 && open_set.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
